@@ sv/lwf_pkg.sv @@
`timescale 1ns / 1ps

package lwf_pkg;

    // field and datapath widths
    localparam int CELL_W     = 12;
    localparam int DIM_W      = 7;
    localparam int COL_W      = 6;
    localparam int HEAD_W     = 2;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int BOUND_W    = 17;

    // grid limits and default store depth
    localparam logic [DIM_W-1:0] DIM_MIN = 7'd1;
    localparam logic [DIM_W-1:0] DIM_MAX = 7'd64;
    localparam int LWF_MAX_CELLS = 4096;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_CELL    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 2'd3;

    // headings
    localparam logic [HEAD_W-1:0] HEAD_NORTH = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_EAST  = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_SOUTH = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_WEST  = 2'd3;

    // reset values
    localparam logic [DIM_W-1:0]  RST_GRID_DIM   = 7'd15;
    localparam logic [CELL_W-1:0] RST_START_CELL = 12'd0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CELL_W-1:0] cell_index;
        logic              cell_is_wall;
    } in_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] position;
        logic [HEAD_W-1:0] heading;
        logic              stuck;
    } out_item_t;

    // zero reads as one column or row, anything above the limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_MIN) r = DIM_MIN;
        if (v > DIM_MAX) r = DIM_MAX;
        return r;
    endfunction

endpackage

@@ sv/lwf_div.sv @@
`timescale 1ns / 1ps

module lwf_div import lwf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [CELL_W-1:0] dividend,
    input  logic [DIM_W-1:0]  divisor,
    output logic              done,
    output logic [CELL_W-1:0] quotient,
    output logic [COL_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(CELL_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CELL_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CELL_W-1:0] dvd_reg, dvd_next;
    logic [COL_W-1:0]  rem_reg, rem_next;

    logic [DIM_W-1:0]  trial;
    logic              fits;

    // one quotient bit per cycle, restoring form
    always_comb begin
        trial     = {rem_reg, dvd_reg[CELL_W-1]};
        fits      = (trial >= divisor);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? COL_W'(trial - divisor) : COL_W'(trial);
            dvd_next = {dvd_reg[CELL_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/lwf_store.sv @@
`timescale 1ns / 1ps

module lwf_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/left_wall_follower_step.sv @@
`timescale 1ns / 1ps

// Left-hand wall follower. Load items write one wall bit per cell of a row-major maze
// store and restart items put the walker back at the start cell and heading; both are
// taken in the idle state. A step item first splits the current cell into row and
// column with a one-bit-per-cycle divider, then probes neighbors through the single read
// port of the cell store, each probe in a probe and a check state: left then ahead, for
// up to four headings. A step keeps s_ready low until its result is placed in the output
// register, which waits while the previous result has not been taken, and yields
// one result with the new cell, heading and a stuck flag set when no move was possible.
// The store has no reset: every cell must be loaded before the first step.
module left_wall_follower_step import lwf_pkg::*; #(
    parameter int MAX_CELLS = LWF_MAX_CELLS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam int ADDR_W = $clog2(MAX_CELLS);
    localparam logic [BOUND_W-1:0] CELL_LIMIT = BOUND_W'(MAX_CELLS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [CELL_W-1:0] start_cell_reg, start_cell_next;
    logic [HEAD_W-1:0] start_head_reg, start_head_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [1:0]        turn_reg, turn_next;
    logic              side_reg, side_next;
    logic              stuck_reg, stuck_next;
    logic              m_valid_reg, m_valid_next;
    logic [CELL_W-1:0] nidx_reg;
    logic              inb_reg;
    out_item_t         m_data_reg;

    logic              s_xfer;
    logic              div_start;
    logic              div_done;
    logic [CELL_W-1:0] row;
    logic [COL_W-1:0]  col;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [HEAD_W-1:0] dir;
    logic [CELL_W:0]   row_x;
    logic [CELL_W:0]   h_x;
    logic [CELL_W:0]   w_x;
    logic [CELL_W:0]   cell_x;
    logic [CELL_W:0]   n_x;
    logic              geo_ok;
    logic              nbr_inb;
    logic [BOUND_W-1:0] n_bound;
    logic [BOUND_W-1:0] ld_bound;
    logic              ld_en;
    logic              rd_wall;
    logic              nbr_open;
    logic              out_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign div_start = s_xfer && (s_data.kind == KIND_STEP);
    assign out_free  = !m_valid_reg || m_ready;

    // row and column of the current cell
    lwf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (cell_reg),
        .divisor   (w_eff),
        .done      (div_done),
        .quotient  (row),
        .remainder (col)
    );

    // neighbor in the probed direction, whether it lies on the grid, and the load write enable
    always_comb begin
        w_eff  = clamp_dim(width_reg);
        h_eff  = clamp_dim(height_reg);
        dir    = side_reg ? head_reg : head_reg + HEAD_WEST;
        row_x  = {1'b0, row};
        h_x    = (CELL_W+1)'(h_eff);
        w_x    = (CELL_W+1)'(w_eff);
        cell_x = {1'b0, cell_reg};
        case (dir)
            HEAD_NORTH: begin
                geo_ok = (row != '0) && ((row_x - 1'b1) < h_x);
                n_x    = cell_x - w_x;
            end
            HEAD_EAST: begin
                geo_ok = ((DIM_W'(col) + 1'b1) < w_eff) && (row_x < h_x);
                n_x    = cell_x + 1'b1;
            end
            HEAD_SOUTH: begin
                geo_ok = (row_x + 1'b1) < h_x;
                n_x    = cell_x + w_x;
            end
            HEAD_WEST: begin
                geo_ok = (col != '0) && (row_x < h_x);
                n_x    = cell_x - 1'b1;
            end
            default: begin
                geo_ok = 1'b0;
                n_x    = cell_x;
            end
        endcase
        n_bound  = BOUND_W'(n_x);
        nbr_inb  = geo_ok && (n_bound < CELL_LIMIT);
        ld_bound = BOUND_W'(s_data.cell_index);
        ld_en    = s_xfer && (s_data.kind == KIND_LOAD) && (ld_bound < CELL_LIMIT);
    end

    lwf_store #(
        .DEPTH (MAX_CELLS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ld_en),
        .wr_addr (ld_bound[ADDR_W-1:0]),
        .wr_data (s_data.cell_is_wall),
        .rd_addr (n_bound[ADDR_W-1:0]),
        .rd_data (rd_wall)
    );

    assign nbr_open = inb_reg && !rd_wall;

    // sequencer, configuration and walker state
    always_comb begin
        state_next      = state_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        start_cell_next = start_cell_reg;
        start_head_next = start_head_reg;
        cell_next       = cell_reg;
        head_next       = head_reg;
        turn_next       = turn_reg;
        side_next       = side_reg;
        stuck_next      = stuck_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_GRID_WIDTH:    width_next      = cfg_wdata[DIM_W-1:0];
                REG_GRID_HEIGHT:   height_next     = cfg_wdata[DIM_W-1:0];
                REG_START_CELL:    start_cell_next = cfg_wdata[CELL_W-1:0];
                REG_START_HEADING: start_head_next = cfg_wdata[HEAD_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    if (s_data.kind == KIND_RESTART) begin
                        cell_next = start_cell_reg;
                        head_next = start_head_reg;
                    end else if (s_data.kind == KIND_STEP) begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_PROBE;
                    turn_next  = '0;
                    side_next  = 1'b0;
                end
            end
            S_PROBE: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (nbr_open) begin
                    cell_next  = nidx_reg;
                    stuck_next = 1'b0;
                    state_next = S_OUT;
                    if (!side_reg) head_next = head_reg + HEAD_WEST;
                end else if (!side_reg) begin
                    side_next  = 1'b1;
                    state_next = S_PROBE;
                end else begin
                    // blocked both ways: turn right and retry, or report stuck after the fourth heading
                    side_next = 1'b0;
                    head_next = head_reg + HEAD_EAST;
                    turn_next = turn_reg + 1'b1;
                    if (turn_reg == 2'd3) begin
                        stuck_next = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and walker registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            width_reg      <= RST_GRID_DIM;
            height_reg     <= RST_GRID_DIM;
            start_cell_reg <= RST_START_CELL;
            start_head_reg <= HEAD_SOUTH;
            cell_reg       <= RST_START_CELL;
            head_reg       <= HEAD_SOUTH;
            turn_reg       <= '0;
            side_reg       <= 1'b0;
            stuck_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            start_cell_reg <= start_cell_next;
            start_head_reg <= start_head_next;
            cell_reg       <= cell_next;
            head_reg       <= head_next;
            turn_reg       <= turn_next;
            side_reg       <= side_next;
            stuck_reg      <= stuck_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // probe result and output payload
    always_ff @(posedge aclk) begin
        if (state_reg == S_PROBE) begin
            nidx_reg <= n_x[CELL_W-1:0];
            inb_reg  <= nbr_inb;
        end
        if (state_reg == S_OUT && out_free) begin
            m_data_reg.position <= cell_reg;
            m_data_reg.heading  <= head_reg;
            m_data_reg.stuck    <= stuck_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ sv/lwf_chk.sv @@
`timescale 1ns / 1ps

module lwf_chk import lwf_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a result is held until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // a step keeps the input side closed while it runs
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == KIND_STEP |=> !s_ready)
        else $error("input open right after a step transfer");

    // loads and restarts never produce a result
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind != KIND_STEP && !m_valid |=> !m_valid)
        else $error("result after a non-step item");

    // a new result only appears at the end of a step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result raised while idle");

endmodule

bind left_wall_follower_step lwf_chk u_lwf_chk (.*);
